/* sv/nddc_pkg.sv */
package nddc_pkg;

  // Width of the query word.
  localparam int VALUE_BITS = 21;
  // Trial divisors reach just past the square root of the query, plus a step of two.
  localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
  // An exponent never exceeds the query width.
  localparam int EXP_BITS = $clog2(VALUE_BITS + 1);
  // Running divisor-count product, saturating well above the largest reportable count.
  localparam int PROD_BITS = 10;
  localparam logic [PROD_BITS-1:0] PROD_MAX = '1;
  // Distinct prime factors of a 21-bit query word stay below sixteen.
  localparam int PRIME_BITS = 4;
  // Result word.
  localparam int COUNT_BITS = 9;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_CYCLE = 3;
  localparam int DIV_STEPS = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int PAD_BITS = DIV_STEPS * BITS_PER_CYCLE;
  localparam int STEP_CNT_BITS = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FINAL,
    S_EMIT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIV_BITS-1:0]   divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIV_BITS-1:0]   remainder;
  } div_rsp_t;

  // Saturating product of the running count and a small factor.
  function automatic logic [PROD_BITS-1:0] sat_mul(input logic [PROD_BITS-1:0] prod,
                                                   input logic [EXP_BITS:0] factor);
    logic [PROD_BITS+EXP_BITS:0] full;
    full = prod * factor;
    if (full > (PROD_BITS + EXP_BITS + 1)'(PROD_MAX)) begin
      return PROD_MAX;
    end
    return full[PROD_BITS-1:0];
  endfunction

endpackage

/* sv/nonprime_divisor_count_top.sv */
// Counts the non-prime divisors (1 included) of each query word by trial division.
// Each query takes roughly sqrt(query)/2 + (number of prime factors) divisions on the shared
// 3-bit-per-cycle divider, each started in S_START and awaited in S_WAIT, then S_FINAL and S_EMIT
// finish it; a zero query skips the divisions and goes straight to S_EMIT after acceptance.
// Throughput: one word at a time; a finished result waits in the output register.
// Reset: rst_ni is asynchronous and active low; it returns the block to idle, output empty.
module nonprime_divisor_count_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [nddc_pkg::VALUE_BITS-1:0] query_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nddc_pkg::COUNT_BITS-1:0] nonprime_count_o
);
  import nddc_pkg::*;

  state_e                  state_q, state_d;
  logic [VALUE_BITS-1:0]   rem_q, rem_d;
  logic [DIV_BITS-1:0]     tdiv_q, tdiv_d;
  logic [EXP_BITS-1:0]     exp_q, exp_d;
  logic [PROD_BITS-1:0]    prod_q, prod_d;
  logic [PRIME_BITS-1:0]   prm_q, prm_d;
  logic                    out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic [PROD_BITS-1:0]    diff;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  nddc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign diff = prod_q - PROD_BITS'(prm_q);

  // Sequencer: issue a division per step and fold the exponents into the count.
  always_comb begin
    state_d          = state_q;
    rem_d            = rem_q;
    tdiv_d           = tdiv_q;
    exp_d            = exp_q;
    prod_d           = prod_q;
    prm_d            = prm_q;
    count_d          = count_q;
    out_valid_d      = out_valid_q && out_stall_i;
    in_stall_o       = (state_q != S_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = rem_q;
    div_req.divisor  = tdiv_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rem_d   = query_value_i;
          tdiv_d  = DIV_BITS'(2);
          exp_d   = '0;
          prm_d   = '0;
          if (query_value_i == '0) begin
            prod_d  = '0;
            state_d = S_EMIT;
          end else begin
            prod_d  = PROD_BITS'(1);
            state_d = S_START;
          end
        end
      end
      S_START: begin
        div_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (exp_q == '0 && div_rsp.quotient < VALUE_BITS'(tdiv_q)) begin
            // The candidate squared exceeds what is left.
            state_d = S_FINAL;
          end else if (div_rsp.remainder == '0) begin
            rem_d   = div_rsp.quotient;
            exp_d   = exp_q + 1'b1;
            state_d = S_START;
          end else begin
            if (exp_q != '0) begin
              prod_d = sat_mul(prod_q, {1'b0, exp_q} + 1'b1);
              prm_d  = prm_q + 1'b1;
              exp_d  = '0;
            end
            tdiv_d  = (tdiv_q == DIV_BITS'(2)) ? DIV_BITS'(3) : tdiv_q + DIV_BITS'(2);
            state_d = S_START;
          end
        end
      end
      S_FINAL: begin
        // Whatever is left above one is a single large prime.
        if (rem_q > VALUE_BITS'(1)) begin
          prod_d = sat_mul(prod_q, (EXP_BITS + 1)'(2));
          prm_d  = prm_q + 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          count_d     = (diff > PROD_BITS'(COUNT_MAX)) ? COUNT_MAX : diff[COUNT_BITS-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working values and the result word.
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    tdiv_q  <= tdiv_d;
    exp_q   <= exp_d;
    prod_q  <= prod_d;
    prm_q   <= prm_d;
    count_q <= count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign nonprime_count_o = count_q;

`ifndef SYNTHESIS
  // A division result only comes back while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_rsp.done |-> state_q == S_WAIT)
    else $error("division result outside the wait state");
  // Trial divisors start at two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_START |-> tdiv_q >= DIV_BITS'(2))
    else $error("trial divisor below two");
  // While factoring, the running product stays nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT || state_q == S_FINAL |-> prod_q != '0)
    else $error("running product is zero");
  // A new result is loaded only into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && state_d == S_IDLE |-> !out_valid_q || !out_stall_i)
    else $error("result overwrote a pending word");
`endif

endmodule

/* sv/nddc_div.sv */
module nddc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nddc_pkg::div_req_t  req_i,
  output nddc_pkg::div_rsp_t  rsp_o
);
  import nddc_pkg::*;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [STEP_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_BITS-1:0]      part_q, part_d;
  logic [PAD_BITS-1:0]      shift_q, shift_d;
  logic [DIV_BITS-1:0]      dsor_q;
  logic [DIV_BITS:0]        trial;

  // Restoring division, several bits per cycle. The shift register sends
  // dividend bits out at the top and takes quotient bits in at the bottom.
  always_comb begin
    part_d  = part_q;
    shift_d = shift_q;
    trial   = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial   = {part_d, shift_d[PAD_BITS-1]};
      shift_d = {shift_d[PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsor_q}) begin
        trial      = trial - {1'b0, dsor_q};
        shift_d[0] = 1'b1;
      end
      part_d = trial[DIV_BITS-1:0];
    end
  end

  // Step counter and completion pulse.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = STEP_CNT_BITS'(DIV_STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers of the division.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      part_q  <= '0;
      shift_q <= PAD_BITS'(req_i.dividend);
      dsor_q  <= req_i.divisor;
    end else if (busy_q) begin
      part_q  <= part_d;
      shift_q <= shift_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = shift_q[VALUE_BITS-1:0];
  assign rsp_o.remainder = part_q;

`ifndef SYNTHESIS
  // A request never arrives while a division is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");
  // The completion pulse follows the last step of a running division.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_d |-> busy_q)
    else $error("divider done without a running division");
  // The divisor is never zero during a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> dsor_q != '0)
    else $error("divider running with zero divisor");
`endif

endmodule

/* tb/nonprime_divisor_count_top_tb.sv */
module nonprime_divisor_count_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nddc_pkg::*;

  localparam int unsigned QUERY_MAX = (1 << VALUE_BITS) - 1;
  localparam int unsigned COUNT_LIMIT = (1 << COUNT_BITS) - 1;
  localparam int REPORT_LIMIT = 10;
  localparam int IDLE_PERCENT = 6;
  localparam int RANDOM_WORDS = 110;
  localparam int SETTLE_CYCLES = 32;

  // One expected result, kept with the query that caused it for messages.
  typedef struct {
    logic [VALUE_BITS-1:0] query;
    logic [COUNT_BITS-1:0] count;
  } count_expect_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] query_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COUNT_BITS-1:0] nonprime_count_o;

  count_expect_t pending_counts[$];
  int            mismatch_count = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  int            rx_hold_cycles = 0;

  nonprime_divisor_count_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .query_value_i    (query_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .nonprime_count_o (nonprime_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Divisor count minus the distinct primes, found by trial division.
  function automatic logic [COUNT_BITS-1:0] count_nonprime_divisors(
    input logic [VALUE_BITS-1:0] query
  );
    longint unsigned rest;
    longint unsigned cand;
    longint unsigned prod;
    longint unsigned primes;
    longint unsigned expo;
    rest = query;
    prod = 1;
    primes = 0;
    cand = 2;
    if (query == '0) begin
      return '0;
    end
    while (cand * cand <= rest) begin
      if (rest % cand == 0) begin
        expo = 0;
        while (rest % cand == 0) begin
          rest = rest / cand;
          expo++;
        end
        prod = prod * (expo + 1);
        primes++;
      end
      cand++;
    end
    // Whatever is left above one is a single prime.
    if (rest > 1) begin
      prod = prod * 2;
      primes++;
    end
    prod = prod - primes;
    if (prod > COUNT_LIMIT) begin
      return COUNT_BITS'(COUNT_LIMIT);
    end
    return prod[COUNT_BITS-1:0];
  endfunction

  // Mostly small queries keep the run short; a few reach the full width.
  function automatic logic [VALUE_BITS-1:0] random_query();
    int unsigned           sel;
    longint unsigned       acc;
    int unsigned           factors[6] = '{2, 3, 5, 7, 11, 13};
    int unsigned           fac;
    sel = $urandom_range(99);
    if (sel < 55) begin
      return VALUE_BITS'($urandom_range(4095));
    end else if (sel < 70) begin
      return VALUE_BITS'($urandom_range(65535));
    end else if (sel < 85) begin
      // Smooth numbers give long exponents and many distinct primes.
      acc = 1;
      repeat ($urandom_range(20, 1)) begin
        fac = factors[$urandom_range(5)];
        if (acc * fac <= QUERY_MAX) begin
          acc = acc * fac;
        end
      end
      return VALUE_BITS'(acc);
    end
    return VALUE_BITS'($urandom_range(QUERY_MAX));
  endfunction

  // Offer one query word and hold it until the block takes it.
  task automatic send_query(input logic [VALUE_BITS-1:0] query);
    count_expect_t entry;
    if (!tx_quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_valid_i <= 1'b1;
    query_value_i <= query;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    entry.query = query;
    entry.count = count_nonprime_divisors(query);
    pending_counts.push_back(entry);
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_counts.size() != 0);
  endtask

  // Field extremes, special values and heavily factored queries.
  task automatic test_special_values();
    logic [VALUE_BITS-1:0] queries[$];
    queries = '{
      '0, 1, 2, 3, 4, 6, 12, 21'h100000, 2000000, 2000001, VALUE_BITS'(QUERY_MAX),
      2097143, 2093809, 1441440, 21'h155555, 21'h0AAAAA, 1048575, 720720, 1024
    };
    foreach (queries[i]) begin
      send_query(queries[i]);
    end
    drain_results();
  endtask

  // Words back to back with neither side idling.
  task automatic test_back_to_back();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (12) begin
      send_query(VALUE_BITS'($urandom_range(1023)));
    end
    drain_results();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // The receiver holds off long enough for a result to back up into the input.
  task automatic test_output_hold();
    @(posedge clk_i);
    rx_hold_cycles = 1500;
    repeat (6) begin
      send_query(VALUE_BITS'($urandom_range(255)));
    end
    drain_results();
  endtask

  // Random mix of sizes with random idling on both sides.
  task automatic test_random_queries();
    repeat (RANDOM_WORDS) begin
      send_query(random_query());
    end
    drain_results();
  endtask

  // Receiver side stalls at random or for a requested stretch.
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_cycles--;
    end else begin
      out_stall_i <= !rx_quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    count_expect_t entry;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result word: nonprime_count %0d", nonprime_count_o);
        end
      end else begin
        entry = pending_counts.pop_front();
        if (nonprime_count_o !== entry.count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("query %0d: nonprime_count expected %0d, got %0d",
                     entry.query, entry.count, nonprime_count_o);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_back_to_back();
    test_output_hold();
    test_random_queries();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_counts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond a run where every query takes the longest path.
  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
